// ===== design/yhr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package yhr_pkg;

  // Default number of fractional bits in the colour matrix coefficients.
  localparam int COEF_FRAC_BITS_DEF = 14;

  // The rotation cosine and sine carry a fixed 14 fractional bits.
  localparam int ANGLE_FRAC_BITS = 14;
  localparam int ANGLE_W         = 16;

  // The rotated I/Q values are split at this bit before the inverse matrix.
  localparam int SPLIT_BITS = 24;

  localparam int CH_W  = 8;
  localparam int PIX_W = 3 * CH_W;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = ANGLE_W;

  // Matrix entries are given in thousandths.
  localparam int MILLI = 1000;

  // Stages from the input register to the output register inclusive.
  localparam int PIPE_DEPTH = 7;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COS = 2'd0,
    REG_SIN = 2'd1
  } cfg_reg_t;

  // RGB to YIQ, row-major, in thousandths.
  function automatic int fwd_milli(input int idx);
    int val;
    case (idx)
      0:       val = 299;
      1:       val = 587;
      2:       val = 114;
      3:       val = 596;
      4:       val = -274;
      5:       val = -321;
      6:       val = 211;
      7:       val = -523;
      8:       val = 311;
      default: val = 0;
    endcase
    return val;
  endfunction

  // YIQ to RGB, row-major, in thousandths. The Y column is exactly one.
  function automatic int inv_milli(input int idx);
    int val;
    case (idx)
      0:       val = 1000;
      1:       val = 956;
      2:       val = 621;
      3:       val = 1000;
      4:       val = -272;
      5:       val = -647;
      6:       val = 1000;
      7:       val = -1107;
      8:       val = 1705;
      default: val = 0;
    endcase
    return val;
  endfunction

  // Thousandths to fixed point, rounded to nearest with halves away from zero.
  function automatic longint to_fixed(input int milli, input int frac);
    longint mag;
    longint q;
    mag = (milli < 0) ? -longint'(milli) : longint'(milli);
    q   = (mag * (longint'(1) << frac) + MILLI / 2) / MILLI;
    return (milli < 0) ? -q : q;
  endfunction

endpackage

`default_nettype wire

// ===== design/yiq_hue_rotate.sv =====
`timescale 1ns / 1ps
`default_nettype none

// YIQ hue rotation for an 8-bit RGB pixel stream. Each item is one pixel; it is
// converted to YIQ, its I/Q plane is rotated by the angle whose cosine and sine
// are held in two configuration registers (signed, 14 fractional bits, reset to
// cos = 1.0 and sin = 0, so the block passes pixels through unchanged after reset
// apart from matrix rounding), and it is converted back to RGB with each channel
// floored and clamped to 0..255. The block takes one item per clock while the output
// is not stalled and passes it through the seven register stages of the pipeline
// (two for the forward matrix, two for the rotation, three for the inverse matrix
// and clamp). Back-pressure stalls only the stages that are full, so bubbles are
// squeezed out. Register writes take effect at once and must only be made while
// no item is in flight. The cosine and sine are used exactly as written, so a pair
// off the unit circle also scales the chroma.
module yiq_hue_rotate import yhr_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // Pixel in.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [PIX_W-1:0]     s_axis_tdata,   // red_in, green_in, blue_in
  // Pixel out.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [PIX_W-1:0]     m_axis_tdata,   // red_out, green_out, blue_out
  // Register writes: index 0 is cos_angle, index 1 is sin_angle.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int YIQ_W = COEF_FRAC_BITS + 11;
  localparam int ROT_W = COEF_FRAC_BITS + 28;
  localparam logic signed [ANGLE_W-1:0] ANGLE_ONE = ANGLE_W'(1 << ANGLE_FRAC_BITS);

  logic signed [ANGLE_W-1:0] cos_angle;
  logic signed [ANGLE_W-1:0] sin_angle;

  logic               yiq_valid;
  logic               yiq_ready;
  logic [3*YIQ_W-1:0] yiq;
  logic               rot_valid;
  logic               rot_ready;
  logic [3*ROT_W-1:0] rot;

  // The registers are plain flops, so a write is always taken at once. An index
  // beyond the two registers is accepted and has no effect.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cos_angle <= ANGLE_ONE;
      sin_angle <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COS: cos_angle <= $signed(cfg_data);
        REG_SIN: sin_angle <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // Forward matrix: RGB to Y, I and Q at scale 2^COEF_FRAC_BITS.
  yhr_fwd #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_fwd (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_rgb    (s_axis_tdata),
    .out_valid (yiq_valid),
    .out_ready (yiq_ready),
    .out_yiq   (yiq)
  );

  // Rotation: Y, I' and Q' at scale 2^(COEF_FRAC_BITS+14), all exact.
  yhr_rot #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_rot (
    .clk       (clk),
    .rst       (rst),
    .cos_angle (cos_angle),
    .sin_angle (sin_angle),
    .in_valid  (yiq_valid),
    .in_ready  (yiq_ready),
    .in_yiq    (yiq),
    .out_valid (rot_valid),
    .out_ready (rot_ready),
    .out_rot   (rot)
  );

  // Inverse matrix, floor to an integer and clamp; the last stage is the
  // output register.
  yhr_inv #(
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_inv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rot_valid),
    .in_ready  (rot_ready),
    .in_rot    (rot),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_rgb   (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== design/yhr_fwd.sv =====
`timescale 1ns / 1ps
`default_nettype none

// RGB to YIQ: nine constant products, then the three row sums.
module yhr_fwd import yhr_pkg::*; #(
  parameter int  COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  localparam int YIQ_W          = COEF_FRAC_BITS + 11
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIX_W-1:0]     in_rgb,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [3*YIQ_W-1:0]   out_yiq
);

  localparam int CW = COEF_FRAC_BITS + 2;
  localparam int PW = COEF_FRAC_BITS + 10;

  localparam logic signed [CW-1:0] FWD_C [9] = '{
    CW'(to_fixed(fwd_milli(0), COEF_FRAC_BITS)),
    CW'(to_fixed(fwd_milli(1), COEF_FRAC_BITS)),
    CW'(to_fixed(fwd_milli(2), COEF_FRAC_BITS)),
    CW'(to_fixed(fwd_milli(3), COEF_FRAC_BITS)),
    CW'(to_fixed(fwd_milli(4), COEF_FRAC_BITS)),
    CW'(to_fixed(fwd_milli(5), COEF_FRAC_BITS)),
    CW'(to_fixed(fwd_milli(6), COEF_FRAC_BITS)),
    CW'(to_fixed(fwd_milli(7), COEF_FRAC_BITS)),
    CW'(to_fixed(fwd_milli(8), COEF_FRAC_BITS))
  };

  logic                    v1;
  logic                    v2;
  logic                    adv1;
  logic                    adv2;
  logic signed [PW-1:0]    prod [9];
  logic signed [YIQ_W-1:0] yiq  [3];

  assign adv2      = !v2 || out_ready;
  assign adv1      = !v1 || adv2;
  assign in_ready  = adv1;
  assign out_valid = v2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= in_valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod[r*3+k] <= PW'(FWD_C[r*3+k]) * PW'($signed({1'b0, in_rgb[k*CH_W +: CH_W]}));
        end
      end
    end
    if (adv2) begin
      for (int r = 0; r < 3; r++) begin
        yiq[r] <= YIQ_W'(prod[r*3]) + YIQ_W'(prod[r*3+1]) + YIQ_W'(prod[r*3+2]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      out_yiq[r*YIQ_W +: YIQ_W] = yiq[r];
    end
  end

endmodule

`default_nettype wire

// ===== design/yhr_rot.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Rotation of the I/Q plane: four products, then the two sums and the scaled Y.
module yhr_rot import yhr_pkg::*; #(
  parameter int  COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  localparam int YIQ_W          = COEF_FRAC_BITS + 11,
  localparam int ROT_W          = YIQ_W + ANGLE_W + 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic signed [ANGLE_W-1:0] cos_angle,
  input  logic signed [ANGLE_W-1:0] sin_angle,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [3*YIQ_W-1:0]        in_yiq,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [3*ROT_W-1:0]        out_rot
);

  localparam int MW = YIQ_W + ANGLE_W;

  logic                    v3;
  logic                    v4;
  logic                    adv3;
  logic                    adv4;
  logic signed [YIQ_W-1:0] y_in;
  logic signed [YIQ_W-1:0] i_in;
  logic signed [YIQ_W-1:0] q_in;
  logic signed [YIQ_W-1:0] y3;
  logic signed [MW-1:0]    ci;
  logic signed [MW-1:0]    sq;
  logic signed [MW-1:0]    si;
  logic signed [MW-1:0]    cq;
  logic signed [ROT_W-1:0] rot [3];

  assign y_in = $signed(in_yiq[0 +: YIQ_W]);
  assign i_in = $signed(in_yiq[YIQ_W +: YIQ_W]);
  assign q_in = $signed(in_yiq[2*YIQ_W +: YIQ_W]);

  assign adv4      = !v4 || out_ready;
  assign adv3      = !v3 || adv4;
  assign in_ready  = adv3;
  assign out_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (adv3) begin
        v3 <= in_valid;
      end
      if (adv4) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      y3 <= y_in;
      ci <= MW'(cos_angle) * MW'(i_in);
      sq <= MW'(sin_angle) * MW'(q_in);
      si <= MW'(sin_angle) * MW'(i_in);
      cq <= MW'(cos_angle) * MW'(q_in);
    end
    if (adv4) begin
      rot[0] <= ROT_W'(y3) <<< ANGLE_FRAC_BITS;
      rot[1] <= ROT_W'(ci) - ROT_W'(sq);
      rot[2] <= ROT_W'(si) + ROT_W'(cq);
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      out_rot[r*ROT_W +: ROT_W] = rot[r];
    end
  end

endmodule

`default_nettype wire

// ===== design/yhr_inv.sv =====
`timescale 1ns / 1ps
`default_nettype none

// YIQ to RGB with floor and clamp. I and Q are split into a signed high part and
// an unsigned low part so that every multiplier stays narrow.
module yhr_inv import yhr_pkg::*; #(
  parameter int  COEF_FRAC_BITS = COEF_FRAC_BITS_DEF,
  localparam int ROT_W          = COEF_FRAC_BITS + 28
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [3*ROT_W-1:0]   in_rot,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIX_W-1:0]     out_rgb
);

  localparam int CW    = COEF_FRAC_BITS + 3;
  localparam int HI_W  = ROT_W - SPLIT_BITS;
  localparam int LPW   = CW + SPLIT_BITS + 1;
  localparam int HPW   = CW + HI_W;
  localparam int LSW   = LPW + 1;
  localparam int HSW   = HPW + 1;
  localparam int SW    = 2 * COEF_FRAC_BITS + 32;
  localparam int SHIFT = 2 * COEF_FRAC_BITS + ANGLE_FRAC_BITS;
  localparam int QW    = SW - SHIFT;

  // Columns for I and Q of each output row; index is row*2 + column.
  localparam logic signed [CW-1:0] INV_C [6] = '{
    CW'(to_fixed(inv_milli(1), COEF_FRAC_BITS)),
    CW'(to_fixed(inv_milli(2), COEF_FRAC_BITS)),
    CW'(to_fixed(inv_milli(4), COEF_FRAC_BITS)),
    CW'(to_fixed(inv_milli(5), COEF_FRAC_BITS)),
    CW'(to_fixed(inv_milli(7), COEF_FRAC_BITS)),
    CW'(to_fixed(inv_milli(8), COEF_FRAC_BITS))
  };

  logic                    v5;
  logic                    v6;
  logic                    v7;
  logic                    adv5;
  logic                    adv6;
  logic                    adv7;
  logic signed [ROT_W-1:0] y_in;
  logic signed [HI_W-1:0]  hi_in [2];
  logic signed [SPLIT_BITS:0] lo_in [2];
  logic signed [ROT_W-1:0] y5;
  logic signed [ROT_W-1:0] y6;
  logic signed [LPW-1:0]   pl [6];
  logic signed [HPW-1:0]   ph [6];
  logic signed [LSW-1:0]   ls [3];
  logic signed [HSW-1:0]   hs [3];
  logic signed [SW-1:0]    total [3];
  logic signed [QW-1:0]    q [3];
  logic [CH_W-1:0]         ch_next [3];
  logic [CH_W-1:0]         ch [3];

  assign y_in = $signed(in_rot[0 +: ROT_W]);

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      hi_in[j] = $signed(in_rot[(j+1)*ROT_W + SPLIT_BITS +: HI_W]);
      lo_in[j] = $signed({1'b0, in_rot[(j+1)*ROT_W +: SPLIT_BITS]});
    end
  end

  assign adv7      = !v7 || out_ready;
  assign adv6      = !v6 || adv7;
  assign adv5      = !v5 || adv6;
  assign in_ready  = adv5;
  assign out_valid = v7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else begin
      if (adv5) begin
        v5 <= in_valid;
      end
      if (adv6) begin
        v6 <= v5;
      end
      if (adv7) begin
        v7 <= v6;
      end
    end
  end

  // The Y column is exactly one, so Y enters as a shift.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      total[r] = (SW'(hs[r]) <<< SPLIT_BITS) + SW'(ls[r]) + (SW'(y6) <<< COEF_FRAC_BITS);
      q[r]     = total[r][SW-1:SHIFT];
      if (q[r][QW-1]) begin
        ch_next[r] = '0;
      end else if (q[r][QW-2:CH_W] != '0) begin
        ch_next[r] = '1;
      end else begin
        ch_next[r] = q[r][CH_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv5) begin
      y5 <= y_in;
      for (int r = 0; r < 3; r++) begin
        for (int j = 0; j < 2; j++) begin
          pl[r*2+j] <= LPW'(INV_C[r*2+j]) * LPW'(lo_in[j]);
          ph[r*2+j] <= HPW'(INV_C[r*2+j]) * HPW'(hi_in[j]);
        end
      end
    end
    if (adv6) begin
      y6 <= y5;
      for (int r = 0; r < 3; r++) begin
        ls[r] <= LSW'(pl[r*2]) + LSW'(pl[r*2+1]);
        hs[r] <= HSW'(ph[r*2]) + HSW'(ph[r*2+1]);
      end
    end
    if (adv7) begin
      for (int r = 0; r < 3; r++) begin
        ch[r] <= ch_next[r];
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      out_rgb[r*CH_W +: CH_W] = ch[r];
    end
  end

endmodule

`default_nettype wire

// ===== design/yhr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Port-level checks on the hue rotation block.
module yhr_checker import yhr_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [PIX_W-1:0] m_axis_tdata
);

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1) + 1;

  logic [CNT_W-1:0] in_flight;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + CNT_W'(in_acc) - CNT_W'(out_acc);
    end
  end

  // A waiting item is held unchanged until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed or vanished while stalled");

  // With the output stage free to move, the pipeline must take a new item.
  a_no_bubble_stall: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready || !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled although the output was free");

  // Every item delivered was accepted earlier and not yet delivered.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> in_flight != '0)
    else $error("output item with nothing in flight");

  // The pipeline never holds more items than it has stages.
  a_depth: assert property (@(posedge clk) disable iff (rst)
    in_flight <= CNT_W'(PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

endmodule

bind yiq_hue_rotate yhr_checker u_yhr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== bench/yiq_hue_rotate_tb.sv =====
`timescale 1ns / 1ps

// Stream test for the YIQ hue rotation block. Pixels are fed through a burst
// and gap driver, results are drained by a receiver that stalls on its own
// pattern, and every result is checked against a bit-exact integer model of
// the colour transform. The angle registers are changed between phases, only
// once the pipeline has drained.
module yiq_hue_rotate_tb;
  import yhr_pkg::*;

  localparam int FRAC_BITS = COEF_FRAC_BITS_DEF;
  localparam int PIXELS_PER_PHASE = 80;
  localparam int PHASES = 12;

  // Register indexes that the block does not decode; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Packed so that red lands in the lowest byte, as on the stream buses.
  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } pixel_t;

  logic                 clk;
  logic                 rst;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [PIX_W-1:0]     s_axis_tdata;   // red_in, green_in, blue_in
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [PIX_W-1:0]     m_axis_tdata;   // red_out, green_out, blue_out
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DAT_W-1:0] cfg_data;

  yiq_hue_rotate #(
    .COEF_FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Colour matrices in thousandths, row-major.
  int rgb_to_yiq_milli [9] = '{299, 587, 114, 596, -274, -321, 211, -523, 311};
  int yiq_to_rgb_milli [9] = '{1000, 956, 621, 1000, -272, -647, 1000, -1107, 1705};

  // Angle settings per phase, cosine and sine in 1.14 format. The list runs
  // through the quarter turns, forty-five degrees, the full 16-bit extremes
  // and a zero pair that collapses the chroma.
  int cos_plan [PHASES] = '{16384, -16384, 0, 0, 11585, -11585, 32767, -32768, -32768, 0,
                            8192, 16384};
  int sin_plan [PHASES] = '{0, 0, 16384, -16384, 11585, 11585, 32767, -32768, 32767, 0,
                            -14189, 16384};

  // Corners of the colour cube, grey and alternating bit patterns, as {blue, green, red}.
  logic [PIX_W-1:0] corner_pixels [13] = '{
    24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000, 24'h00FFFF, 24'hFF00FF,
    24'hFFFF00, 24'h808080, 24'h030201, 24'h7F01FE, 24'hAA55AA, 24'h55AA55
  };

  pixel_t pending_pixels [$];
  pixel_t expected_pixels [$];

  // Shadow of the angle registers, updated as the block sees the writes.
  logic signed [CFG_DAT_W-1:0] cos_shadow;
  logic signed [CFG_DAT_W-1:0] sin_shadow;

  logic pix_fire;
  int   cfg_count;
  int   err_count;
  int   pixels_sent;
  int   pixels_checked;
  int   settings_used;

  // Idling knobs; gap_max and stall_pct are changed only between phases.
  int gap_max;
  int stall_pct;
  int burst_left;
  int gap_left;
  int stall_left;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("Run stopped by the watchdog with %0d results still awaited",
             expected_pixels.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 40)
      $display("ERROR at %0t ns: %s", $time, what);
  endtask

  // Matrix entry in fixed point, rounded to nearest with halves away from zero.
  function automatic longint coef_q(input int milli);
    longint mag;
    longint q;
    mag = (milli < 0) ? -longint'(milli) : longint'(milli);
    q = (mag * (longint'(1) << FRAC_BITS) + longint'(MILLI / 2)) / longint'(MILLI);
    return (milli < 0) ? -q : q;
  endfunction

  // Expected output pixel. With 14 fractional bits every intermediate fits in
  // 64 bits, so the exact sums are formed directly and floored by an arithmetic
  // shift before the clamp.
  function automatic pixel_t rotate_hue(input pixel_t px,
                                        input logic signed [CFG_DAT_W-1:0] c_q,
                                        input logic signed [CFG_DAT_W-1:0] s_q);
    longint chan [3];
    longint yiq [3];
    longint rot [3];
    longint acc;
    logic [CH_W-1:0] out_ch [3];
    pixel_t res;
    chan[0] = longint'(px.red);
    chan[1] = longint'(px.green);
    chan[2] = longint'(px.blue);
    for (int r = 0; r < 3; r++)
      yiq[r] = coef_q(rgb_to_yiq_milli[3*r]) * chan[0]
             + coef_q(rgb_to_yiq_milli[3*r+1]) * chan[1]
             + coef_q(rgb_to_yiq_milli[3*r+2]) * chan[2];
    rot[0] = yiq[0] <<< ANGLE_FRAC_BITS;
    rot[1] = longint'(c_q) * yiq[1] - longint'(s_q) * yiq[2];
    rot[2] = longint'(s_q) * yiq[1] + longint'(c_q) * yiq[2];
    for (int r = 0; r < 3; r++) begin
      acc = coef_q(yiq_to_rgb_milli[3*r]) * rot[0]
          + coef_q(yiq_to_rgb_milli[3*r+1]) * rot[1]
          + coef_q(yiq_to_rgb_milli[3*r+2]) * rot[2];
      acc = acc >>> (2 * FRAC_BITS + ANGLE_FRAC_BITS);
      if (acc < 0)
        acc = 0;
      else if (acc > 255)
        acc = 255;
      out_ch[r] = CH_W'(acc);
    end
    res.red   = out_ch[0];
    res.green = out_ch[1];
    res.blue  = out_ch[2];
    return res;
  endfunction

  // Mostly uniform pixels, with some built only from saturated channels and some greys.
  function automatic pixel_t random_pixel();
    pixel_t px;
    int kind;
    kind = $urandom_range(9);
    px = pixel_t'(PIX_W'($urandom));
    if (kind == 0) begin
      px.red   = px.red[0]   ? 8'hFF : 8'h00;
      px.green = px.green[0] ? 8'hFF : 8'h00;
      px.blue  = px.blue[0]  ? 8'hFF : 8'h00;
    end else if (kind == 1) begin
      px.green = px.red;
      px.blue  = px.red;
    end
    return px;
  endfunction

  task automatic write_angle_reg(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DAT_W-1:0] val);
    int seen;
    seen = cfg_count;
    @(negedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    wait (cfg_count != seen);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every pixel has been sent and every result has come back.
  // Each check is made just after the falling edge, once the driver has settled.
  task automatic wait_drained();
    do begin
      @(negedge clk);
      #1;
    end while (pending_pixels.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0);
    repeat (PIPE_DEPTH) @(negedge clk);
  endtask

  // Sender: bursts of random length, each followed by a random gap.
  always @(negedge clk) begin : drive_pixels
    logic             nxt_valid;
    logic [PIX_W-1:0] nxt_data;
    nxt_valid = s_axis_tvalid;
    nxt_data  = s_axis_tdata;
    if (rst !== 1'b0) begin
      nxt_valid = 1'b0;
    end else if (!s_axis_tvalid || pix_fire) begin
      nxt_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_pixels.size() != 0) begin
        nxt_data  = pending_pixels.pop_front();
        nxt_valid = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left   = (gap_max == 0) ? 0 : $urandom_range(gap_max);
        end
      end
    end
    s_axis_tvalid <= nxt_valid;
    s_axis_tdata  <= nxt_data;
  end

  // Receiver: stalls start at random and each has a random length.
  always @(negedge clk) begin
    if (!rst) begin
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(7);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Everything is sampled at the rising edge: register writes, accepted
  // pixels (predicted at once with the current angle) and accepted results.
  always @(posedge clk) begin : watch_streams
    pixel_t got;
    pixel_t want;
    if (rst) begin
      cos_shadow = CFG_DAT_W'(1 << ANGLE_FRAC_BITS);
      sin_shadow = '0;
      pix_fire <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_COS: cos_shadow = cfg_data;
          REG_SIN: sin_shadow = cfg_data;
          default: ;
        endcase
        cfg_count <= cfg_count + 1;
      end
      pix_fire <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_pixels.push_back(rotate_hue(pixel_t'(s_axis_tdata), cos_shadow, sin_shadow));
        pixels_sent++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = pixel_t'(m_axis_tdata);
        if (expected_pixels.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
        end else begin
          want = expected_pixels.pop_front();
          if (got.red !== want.red)
            report_mismatch($sformatf("result %0d red %0d, expected %0d",
                                      pixels_checked, got.red, want.red));
          if (got.green !== want.green)
            report_mismatch($sformatf("result %0d green %0d, expected %0d",
                                      pixels_checked, got.green, want.green));
          if (got.blue !== want.blue)
            report_mismatch($sformatf("result %0d blue %0d, expected %0d",
                                      pixels_checked, got.blue, want.blue));
        end
        pixels_checked++;
      end
    end
  end

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    cfg_count     = 0;
    err_count     = 0;
    pixels_sent   = 0;
    pixels_checked = 0;
    settings_used = 1;
    gap_max       = 3;
    stall_pct     = 20;
    burst_left    = 1;
    gap_left      = 0;
    stall_left    = 0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The reset angle must pass pixels through the matrices unrotated.
    foreach (corner_pixels[i])
      pending_pixels.push_back(pixel_t'(corner_pixels[i]));
    wait_drained();

    for (int k = 0; k < PHASES; k++) begin
      // Every third phase runs with no idling on either side.
      if (k % 3 == 0) begin
        gap_max   = 0;
        stall_pct = 0;
      end else begin
        gap_max   = (k % 3 == 1) ? 2 : 8;
        stall_pct = (k % 3 == 1) ? 25 : 60;
      end
      if (k == PHASES - 1) begin
        // Last phase: an arbitrary pair anywhere in the 16-bit range.
        write_angle_reg(REG_COS, CFG_DAT_W'($urandom));
        write_angle_reg(REG_SIN, CFG_DAT_W'($urandom));
      end else begin
        write_angle_reg(REG_COS, CFG_DAT_W'(cos_plan[k]));
        write_angle_reg(REG_SIN, CFG_DAT_W'(sin_plan[k]));
      end
      if (k == 4) begin
        write_angle_reg(REG_SPARE_A, CFG_DAT_W'($urandom));
        write_angle_reg(REG_SPARE_B, CFG_DAT_W'($urandom));
      end
      settings_used++;
      pending_pixels.push_back(pixel_t'(PIX_W'(0)));
      pending_pixels.push_back(pixel_t'({PIX_W{1'b1}}));
      repeat (PIXELS_PER_PHASE) pending_pixels.push_back(random_pixel());
      wait_drained();
    end

    $display("Sent %0d pixels under %0d angle settings, %0d register writes",
             pixels_sent, settings_used, cfg_count);
    $display("Checked %0d results with bursty input and receiver stalls",
             pixels_checked);
    if (err_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
design/yhr_pkg.sv
design/yhr_fwd.sv
design/yhr_rot.sv
design/yhr_inv.sv
design/yiq_hue_rotate.sv
design/yhr_checker.sv
bench/yiq_hue_rotate_tb.sv
